// ----- rtl/core/vap_pkg.sv -----
// shared types and constants for the volume axis projection unit
package vap_pkg;

    localparam int MAX_DIM_DEF    = 256;
    localparam int VOXEL_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 40;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CFG_IDX_BITS-1:0] REG_PROJ_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_USE_MAXIMUM = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z      = 3'd4;

    localparam logic [2:0] MODE_ALONG_Z = 3'd0;
    localparam logic [2:0] MODE_ALONG_X = 3'd1;
    localparam logic [2:0] MODE_ALONG_Y = 3'd2;
    localparam logic [2:0] MODE_ONTO_Y  = 3'd3;
    localparam logic [2:0] MODE_ONTO_X  = 3'd4;
    localparam logic [2:0] MODE_ONTO_Z  = 3'd5;

    localparam int OUT_COORD_BITS = 8;

endpackage

// ----- rtl/core/vap_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module vap_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/vap_front.sv -----
// front end: position tracking and classification of each voxel word
module vap_front
    import vap_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF,
    localparam int DB = $clog2(MAX_DIM),
    localparam int SB = DB + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart,
    input  logic [2:0]            proj_mode,
    input  logic [SB-1:0]         size_x,
    input  logic [SB-1:0]         size_y,
    input  logic [SB-1:0]         size_z,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VOXEL_BITS-1:0] in_value,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [VOXEL_BITS-1:0] q_value,
    output logic [DB-1:0]         q_u,
    output logic [DB-1:0]         q_w,
    output logic                  q_first,
    output logic                  q_done,
    output logic                  q_fold,
    output logic                  q_last
);

    logic [DB-1:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic ex, ey, ez, acc;
    logic [DB-1:0] u, w;
    logic first, done, fold;

    // sizes of zero act as one, sizes above the maximum as the maximum
    function automatic logic is_end(input logic [DB-1:0] p, input logic [SB-1:0] s);
        logic [SB-1:0] e;
        begin
            e = (s == '0) ? SB'(1) : ((s > SB'(MAX_DIM)) ? SB'(MAX_DIM) : s);
            is_end = ({1'b0, p} + SB'(1)) >= e;
        end
    endfunction

    assign ex = is_end(x_reg, size_x);
    assign ey = is_end(y_reg, size_y);
    assign ez = is_end(z_reg, size_z);

    assign in_ready = !q_valid || q_ready;
    assign acc = in_valid && in_ready;

    always_comb begin
        u = '0; w = '0; first = 1'b0; done = 1'b0; fold = 1'b1;
        unique case (proj_mode)
            MODE_ALONG_Z: begin u = x_reg; w = y_reg; first = z_reg == '0; done = ez; end
            MODE_ALONG_X: begin u = y_reg; w = z_reg; first = x_reg == '0; done = ex; end
            MODE_ALONG_Y: begin u = z_reg; w = x_reg; first = y_reg == '0; done = ey; end
            MODE_ONTO_Y: begin
                u = y_reg; first = x_reg == '0 && z_reg == '0; done = ex && ez;
            end
            MODE_ONTO_X: begin
                u = x_reg; first = y_reg == '0 && z_reg == '0; done = ey && ez;
            end
            MODE_ONTO_Z: begin
                u = z_reg; first = x_reg == '0 && y_reg == '0; done = ex && ey;
            end
            default: fold = 1'b0;
        endcase
    end

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        if (!ex) begin
            x_next = x_reg + DB'(1);
        end else begin
            x_next = '0;
            if (!ey) begin
                y_next = y_reg + DB'(1);
            end else begin
                y_next = '0;
                z_next = ez ? '0 : z_reg + DB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            x_reg <= '0; y_reg <= '0; z_reg <= '0;
        end else if (acc) begin
            x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid <= 1'b0;
        end else if (in_ready) begin
            q_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            q_value <= in_value;
            q_u     <= u;
            q_w     <= w;
            q_first <= first;
            q_done  <= done;
            q_fold  <= fold;
            q_last  <= ex && ey && ez;
        end
    end

endmodule

// ----- rtl/core/vap_back.sv -----
// back end: accumulator read-modify-write pipeline with forwarding and output skid
module vap_back
    import vap_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF,
    localparam int DB = $clog2(MAX_DIM),
    localparam int AB = 2 * DB
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  use_maximum,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [VOXEL_BITS-1:0] q_value,
    input  logic [DB-1:0]         q_u,
    input  logic [DB-1:0]         q_w,
    input  logic                  q_first,
    input  logic                  q_done,
    input  logic                  q_fold,
    input  logic                  q_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_COORD_BITS-1:0] m_u,
    output logic [OUT_COORD_BITS-1:0] m_v,
    output logic [ACC_BITS-1:0]   m_value,
    output logic                  m_last
);

    localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

    // stage 1: ram read in flight
    logic                  s1_valid_reg;
    logic [VOXEL_BITS-1:0] s1_value_reg;
    logic [DB-1:0]         s1_u_reg, s1_w_reg;
    logic                  s1_first_reg, s1_done_reg, s1_fold_reg, s1_last_reg;
    logic [AB-1:0]         s1_addr_reg;
    // last written entry, for forwarding into the next read
    logic                  wb_valid_reg;
    logic [AB-1:0]         wb_addr_reg;
    logic [ACC_BITS-1:0]   wb_data_reg;
    // output skid: main and spare
    logic                      o_valid_reg, sk_valid_reg;
    logic [OUT_COORD_BITS-1:0] o_u_reg, o_v_reg, sk_u_reg, sk_v_reg;
    logic [ACC_BITS-1:0]       o_val_reg, sk_val_reg;
    logic                      o_last_reg, sk_last_reg;

    logic [AB-1:0]         q_addr;
    logic [ACC_BITS-1:0]   rd_data, old_val, new_val;
    logic signed [ACC_BITS-1:0] old_s, v_s;
    logic signed [ACC_BITS:0]   sum;
    logic                  adv, s1_emit, wr_en;

    function automatic logic signed [ACC_BITS-1:0] q_value_ext(input logic [VOXEL_BITS-1:0] d);
        q_value_ext = {{(ACC_BITS-VOXEL_BITS){d[VOXEL_BITS-1]}}, d};
    endfunction

    assign q_addr = {q_w, q_u};
    // pipeline advances unless the spare slot is holding a result
    assign adv     = !sk_valid_reg;
    assign q_ready = adv;

    vap_ram #(.WIDTH(ACC_BITS), .DEPTH(1 << AB)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_val),
        .rd_en   (adv),
        .rd_addr (q_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (s1_first_reg) begin
            old_val = '0;
        end else if (wb_valid_reg && wb_addr_reg == s1_addr_reg) begin
            old_val = wb_data_reg;
        end else begin
            old_val = rd_data;
        end
        old_s = old_val;
        v_s   = ACC_BITS'(signed'(q_value_ext(s1_value_reg)));
        sum   = {old_s[ACC_BITS-1], old_s} + {v_s[ACC_BITS-1], v_s};
        if (use_maximum) begin
            new_val = (v_s > old_s) ? v_s : old_s;
        end else if (sum > (ACC_BITS+1)'(ACC_HI)) begin
            new_val = ACC_HI;
        end else if (sum < $signed({1'b1, ACC_LO})) begin
            new_val = ACC_LO;
        end else begin
            new_val = sum[ACC_BITS-1:0];
        end
    end

    assign wr_en   = s1_valid_reg && s1_fold_reg && adv;
    assign s1_emit = wr_en && s1_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_valid;
            wb_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_value_reg <= q_value;
            s1_u_reg     <= q_u;
            s1_w_reg     <= q_w;
            s1_first_reg <= q_first;
            s1_done_reg  <= q_done;
            s1_fold_reg  <= q_fold;
            s1_last_reg  <= q_last;
            s1_addr_reg  <= q_addr;
            wb_addr_reg  <= s1_addr_reg;
            wb_data_reg  <= new_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            if (!o_valid_reg || m_ready) begin
                if (sk_valid_reg) begin
                    o_valid_reg  <= 1'b1;
                    sk_valid_reg <= 1'b0;
                end else begin
                    o_valid_reg <= s1_emit;
                end
            end else if (s1_emit) begin
                sk_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!o_valid_reg || m_ready) begin
            if (sk_valid_reg) begin
                o_u_reg <= sk_u_reg; o_v_reg <= sk_v_reg;
                o_val_reg <= sk_val_reg; o_last_reg <= sk_last_reg;
            end else begin
                o_u_reg <= OUT_COORD_BITS'(s1_u_reg); o_v_reg <= OUT_COORD_BITS'(s1_w_reg);
                o_val_reg <= new_val; o_last_reg <= s1_last_reg;
            end
        end else if (s1_emit) begin
            sk_u_reg <= OUT_COORD_BITS'(s1_u_reg); sk_v_reg <= OUT_COORD_BITS'(s1_w_reg);
            sk_val_reg <= new_val; sk_last_reg <= s1_last_reg;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_u     = o_u_reg;
    assign m_v     = o_v_reg;
    assign m_value = o_val_reg;
    assign m_last  = o_last_reg;

endmodule

// ----- rtl/core/volume_axis_projection_unit.sv -----
// top level of the volume axis projection unit
// path: front queue register, back stage s1 (ram read, fold, write), output register
// throughput: one voxel word per cycle, one accumulator read-modify-write each,
// while the output spare slot is empty; the front holds one queued word
// reset: synchronous active-low aresetn clears handshake state, registers and position
// the accumulator ram is not cleared; the first voxel of each entry folds into zero
module volume_axis_projection_unit
    import vap_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [VOXEL_BITS-1:0]     s_voxel_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_COORD_BITS-1:0] m_out_u,
    output logic [OUT_COORD_BITS-1:0] m_out_v,
    output logic [ACC_BITS-1:0]       m_out_value,
    output logic                      m_out_last
);

    localparam int DB = $clog2(MAX_DIM);
    localparam int SB = DB + 1;

    logic [2:0] mode_reg;
    logic       max_reg;
    logic [CFG_DATA_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic       restart;
    logic [SB-1:0] sx, sy, sz;

    logic                  q_valid, q_ready, q_first, q_done, q_fold, q_last;
    logic [VOXEL_BITS-1:0] q_value;
    logic [DB-1:0]         q_u, q_w;

    assign restart = cfg_wr_en && cfg_wr_index <= REG_SIZE_Z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ALONG_Z;
            max_reg  <= 1'b0;
            sx_reg   <= CFG_DATA_BITS'(256);
            sy_reg   <= CFG_DATA_BITS'(256);
            sz_reg   <= CFG_DATA_BITS'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PROJ_MODE:   mode_reg <= cfg_wr_data[2:0];
                REG_USE_MAXIMUM: max_reg  <= cfg_wr_data[0];
                REG_SIZE_X:      sx_reg   <= cfg_wr_data;
                REG_SIZE_Y:      sy_reg   <= cfg_wr_data;
                REG_SIZE_Z:      sz_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // clamp the register value into the position counter range
    function automatic logic [SB-1:0] clamp(input logic [CFG_DATA_BITS-1:0] s);
        clamp = ({{(32-CFG_DATA_BITS){1'b0}}, s} > 32'(MAX_DIM)) ? SB'(MAX_DIM) : SB'(s);
    endfunction

    assign sx = clamp(sx_reg);
    assign sy = clamp(sy_reg);
    assign sz = clamp(sz_reg);

    vap_front #(.MAX_DIM(MAX_DIM), .VOXEL_BITS(VOXEL_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .restart(restart),
        .proj_mode(mode_reg), .size_x(sx), .size_y(sy), .size_z(sz),
        .in_valid(s_valid), .in_ready(s_ready), .in_value(s_voxel_value),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value),
        .q_u(q_u), .q_w(q_w), .q_first(q_first), .q_done(q_done),
        .q_fold(q_fold), .q_last(q_last)
    );

    vap_back #(.MAX_DIM(MAX_DIM), .VOXEL_BITS(VOXEL_BITS), .ACC_BITS(ACC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .use_maximum(max_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value),
        .q_u(q_u), .q_w(q_w), .q_first(q_first), .q_done(q_done),
        .q_fold(q_fold), .q_last(q_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_u(m_out_u), .m_v(m_out_v),
        .m_value(m_out_value), .m_last(m_out_last)
    );

endmodule
